[hdl/gff_pkg.sv]
// Shared types and constants of the grayscale frame flipper.
package gff_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    // Flip modes; the fourth code behaves as both flips.
    localparam logic [1:0] MODE_MIRROR = 2'd0;
    localparam logic [1:0] MODE_VFLIP  = 2'd1;
    localparam logic [1:0] MODE_BOTH   = 2'd2;

    // Operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_VALID      = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    // Gray conversion: floor((21*r + 72*g + 7*b) / 100).
    // The sum stays below 25600, so the division is a multiplication by
    // ceil(2^19 / 100) followed by a shift.
    localparam int GRAY_WR    = 21;
    localparam int GRAY_WG    = 72;
    localparam int GRAY_WB    = 7;
    localparam int SUM_W      = 15;
    localparam int RECIP_W    = 13;
    localparam int GRAY_RECIP = 5243;
    localparam int GRAY_SHIFT = 19;
    localparam int PROD_W     = SUM_W + RECIP_W;

    typedef struct packed {
        logic       opcode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_in_item;

    typedef struct packed {
        logic [7:0] gray;
        logic       row_end;
        logic       last;
        logic [1:0] status;
    } t_out_item;

endpackage

[hdl/gray_frame_flipper.sv]
// Top level of the grayscale frame flipper: control, address generation and frame store.
// While a load item's gray value is written to the frame store, o_busy is high and no
// new item is taken, so loads cannot be accepted back to back.
// Reads follow each other every cycle while no load write is pending; every read gives
// its result on o_valid via the store and result registers; the receiver cannot stall.
// Reset clears the geometry to 1x1, the mode to mirror and all frame counters; the frame
// store is not cleared and is only read at entries written since the frame began.
module gray_frame_flipper #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  gff_pkg::t_in_item                i_item,
    output logic                             o_busy,
    output logic                             o_valid,
    output gff_pkg::t_out_item               o_result,
    input  logic                             i_cfg_we,
    input  logic [gff_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gff_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Widths that follow from the largest frame.
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_WW = (WW > gff_pkg::CFG_DATA_W) ? WW : gff_pkg::CFG_DATA_W;
    localparam int CMP_HW = (HW > gff_pkg::CFG_DATA_W) ? HW : gff_pkg::CFG_DATA_W;
    localparam int PW     = RW + WW;

    // Geometry is held already clamped to the legal range, so the datapath never
    // has to deal with a zero or oversized dimension.
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [1:0]    r_mode;

    // Load side: raster position and linear address of the next pixel to store.
    logic [CW-1:0] r_ld_col;
    logic [RW-1:0] r_ld_row;
    logic [AW-1:0] r_ld_addr;
    logic          r_full;

    // Read side: output raster position; r_done is set after the last pixel.
    logic [CW-1:0] r_rd_col;
    logic [RW-1:0] r_rd_row;
    logic          r_done;

    // Pipeline between acceptance, the memory access and the result register.
    logic                r_ld_pend;
    logic [AW-1:0]       r_wr_addr;
    logic                r_rd_pend;
    logic                r_rd_row_end;
    logic                r_rd_last;
    logic [1:0]          r_rd_status;
    logic                r_out_valid;
    gff_pkg::t_out_item  r_out;

    logic [CMP_WW-1:0] cfg_w_ext;
    logic [CMP_HW-1:0] cfg_h_ext;
    logic [WW-1:0]     w_clamped;
    logic [HW-1:0]     h_clamped;
    logic [CW-1:0]     wm1;
    logic [RW-1:0]     hm1;

    logic          acc;
    logic          ld_acc;
    logic          rd_acc;
    logic [CW-1:0] ld_col;
    logic [RW-1:0] ld_row;
    logic [AW-1:0] ld_addr;
    logic          ld_row_end;
    logic          ld_last;

    logic          rd_ok;
    logic          rd_row_end;
    logic          rd_last;
    logic [1:0]    rd_status;
    logic          hmirror;
    logic          vflip;
    logic [CW-1:0] src_col;
    logic [RW-1:0] src_row;
    logic [PW-1:0] row_base;
    logic [AW-1:0] rd_addr;
    logic [7:0]    gray;
    logic [7:0]    ram_rdata;

    // Clamp the written dimension to 1..MAX; zero counts as one.
    assign cfg_w_ext = CMP_WW'(i_cfg_data);
    assign cfg_h_ext = CMP_HW'(i_cfg_data);

    always_comb begin
        if (cfg_w_ext == '0) begin
            w_clamped = WW'(1);
        end else if (cfg_w_ext > CMP_WW'(MAX_WIDTH)) begin
            w_clamped = WW'(MAX_WIDTH);
        end else begin
            w_clamped = WW'(cfg_w_ext);
        end
        if (cfg_h_ext == '0) begin
            h_clamped = HW'(1);
        end else if (cfg_h_ext > CMP_HW'(MAX_HEIGHT)) begin
            h_clamped = HW'(MAX_HEIGHT);
        end else begin
            h_clamped = HW'(cfg_h_ext);
        end
    end

    assign wm1 = CW'(r_w - WW'(1));
    assign hm1 = RW'(r_h - HW'(1));

    // Only a pending store write holds off new items, so that a read never
    // meets a write to the same entry in the same cycle.
    assign o_busy = r_ld_pend;
    assign acc    = i_start && !o_busy;
    assign ld_acc = acc && (i_item.opcode == gff_pkg::OP_LOAD);
    assign rd_acc = acc && (i_item.opcode == gff_pkg::OP_READ);

    // A load into a full frame begins a new frame at its first pixel.
    assign ld_col     = r_full ? '0 : r_ld_col;
    assign ld_row     = r_full ? '0 : r_ld_row;
    assign ld_addr    = r_full ? '0 : r_ld_addr;
    assign ld_row_end = (ld_col == wm1);
    assign ld_last    = ld_row_end && (ld_row == hm1);

    // Read status and the row and frame marks of the output position.
    assign rd_ok      = r_full && !r_done;
    assign rd_row_end = (r_rd_col == wm1);
    assign rd_last    = rd_row_end && (r_rd_row == hm1);

    always_comb begin
        if (!r_full) begin
            rd_status = gff_pkg::ST_NOT_LOADED;
        end else if (r_done) begin
            rd_status = gff_pkg::ST_EMPTY;
        end else begin
            rd_status = gff_pkg::ST_VALID;
        end
    end

    // Source position in the stored frame. Mirror code flips columns only, the
    // vertical code rows only, and both remaining codes turn the frame round.
    assign hmirror  = (r_mode != gff_pkg::MODE_VFLIP);
    assign vflip    = (r_mode != gff_pkg::MODE_MIRROR);
    assign src_col  = hmirror ? CW'(wm1 - r_rd_col) : r_rd_col;
    assign src_row  = vflip ? RW'(hm1 - r_rd_row) : r_rd_row;
    assign row_base = PW'(src_row) * PW'(r_w);
    assign rd_addr  = AW'(row_base + PW'(src_col));

    gff_gray u_gray (
        .i_clk   (i_clk),
        .i_load  (ld_acc),
        .i_blue  (i_item.blue),
        .i_green (i_item.green),
        .i_red   (i_item.red),
        .o_gray  (gray)
    );

    // The store is written in the cycle after a load is accepted, once the
    // gray value has left the conversion unit.
    gff_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_ld_pend),
        .i_waddr (r_wr_addr),
        .i_wdata (gray),
        .i_re    (rd_acc && rd_ok),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= WW'(1);
            r_h         <= HW'(1);
            r_mode      <= gff_pkg::MODE_MIRROR;
            r_ld_col    <= '0;
            r_ld_row    <= '0;
            r_ld_addr   <= '0;
            r_full      <= 1'b0;
            r_rd_col    <= '0;
            r_rd_row    <= '0;
            r_done      <= 1'b0;
            r_ld_pend   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ld_pend   <= ld_acc;
            r_rd_pend   <= rd_acc;
            r_out_valid <= r_rd_pend;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gff_pkg::CFG_WIDTH, gff_pkg::CFG_HEIGHT: begin
                        // A change of geometry restarts the frame.
                        if (i_cfg_idx == gff_pkg::CFG_WIDTH) begin
                            r_w <= w_clamped;
                        end else begin
                            r_h <= h_clamped;
                        end
                        r_ld_col  <= '0;
                        r_ld_row  <= '0;
                        r_ld_addr <= '0;
                        r_full    <= 1'b0;
                        r_rd_col  <= '0;
                        r_rd_row  <= '0;
                        r_done    <= 1'b0;
                    end
                    gff_pkg::CFG_MODE: begin
                        r_mode <= i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (ld_acc) begin
                if (r_full) begin
                    r_rd_col <= '0;
                    r_rd_row <= '0;
                    r_done   <= 1'b0;
                end
                r_full    <= ld_last;
                r_ld_addr <= AW'(ld_addr + AW'(1));
                if (ld_row_end) begin
                    r_ld_col <= '0;
                    r_ld_row <= RW'(ld_row + RW'(1));
                end else begin
                    r_ld_col <= CW'(ld_col + CW'(1));
                    r_ld_row <= ld_row;
                end
            end else if (rd_acc && rd_ok) begin
                if (rd_last) begin
                    r_done   <= 1'b1;
                    r_rd_col <= '0;
                    r_rd_row <= '0;
                end else if (rd_row_end) begin
                    r_rd_col <= '0;
                    r_rd_row <= RW'(r_rd_row + RW'(1));
                end else begin
                    r_rd_col <= CW'(r_rd_col + CW'(1));
                end
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge i_clk) begin
        if (ld_acc) begin
            r_wr_addr <= ld_addr;
        end
        if (rd_acc) begin
            r_rd_row_end <= rd_ok && rd_row_end;
            r_rd_last    <= rd_ok && rd_last;
            r_rd_status  <= rd_status;
        end
        if (r_rd_pend) begin
            r_out.gray    <= (r_rd_status == gff_pkg::ST_VALID) ? ram_rdata : 8'd0;
            r_out.row_end <= r_rd_row_end;
            r_out.last    <= r_rd_last;
            r_out.status  <= r_rd_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hdl/gff_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module gff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/gff_gray.sv]
// BGR to gray conversion: weighted sum registered, then division by reciprocal.
module gff_gray (
    input  logic       i_clk,
    input  logic       i_load,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    output logic [7:0] o_gray
);

    logic [gff_pkg::SUM_W-1:0]  r_sum;
    logic [gff_pkg::PROD_W-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= gff_pkg::SUM_W'(i_red)   * gff_pkg::SUM_W'(gff_pkg::GRAY_WR)
                   + gff_pkg::SUM_W'(i_green) * gff_pkg::SUM_W'(gff_pkg::GRAY_WG)
                   + gff_pkg::SUM_W'(i_blue)  * gff_pkg::SUM_W'(gff_pkg::GRAY_WB);
        end
    end

    // The reciprocal is exact for every sum below 43690.
    assign prod   = gff_pkg::PROD_W'(r_sum) * gff_pkg::PROD_W'(gff_pkg::GRAY_RECIP);
    assign o_gray = prod[gff_pkg::GRAY_SHIFT +: 8];

endmodule

[hdl/gff_checker.sv]
// Port-level checker of the grayscale frame flipper and its bind statement.
module gff_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input gff_pkg::t_in_item  i_item,
    input logic               o_busy,
    input logic               o_valid,
    input gff_pkg::t_out_item o_result
);

    // Every accepted read gives exactly one result on o_valid.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.opcode == gff_pkg::OP_READ) |=> ##1 o_valid)
        else $error("accepted read gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy && i_item.opcode == gff_pkg::OP_READ, 2))
        else $error("result without a read");

    // A load holds off the next item for exactly one cycle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.opcode == gff_pkg::OP_LOAD) |=> o_busy ##1 !o_busy)
        else $error("load interlock wrong");

    // Marks and gray are clear unless the pixel is valid; the frame end is a row end.
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.status == gff_pkg::ST_VALID) ?
            (!o_result.last || o_result.row_end) :
            (o_result.gray == 8'd0 && !o_result.row_end && !o_result.last)))
        else $error("inconsistent result marks");

endmodule

bind gray_frame_flipper gff_checker u_gff_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
